@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/far_pkg.sv @@
// ----------------------------------------------------------------------------
// far_pkg
// types and constants for the fraction adder with gcd reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package far_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int PW        = 2 * IN_WIDTH;
  localparam int SUM_NUM_W = 33;
  localparam int SUM_DEN_W = 31;
  localparam int CNT_W     = $clog2(PW);
  localparam int EXT_W     = (PW + 1 > SUM_NUM_W) ? PW + 1 : SUM_NUM_W;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] num_a;
    logic signed [IN_WIDTH-1:0] den_a;
    logic signed [IN_WIDTH-1:0] num_b;
    logic signed [IN_WIDTH-1:0] den_b;
  } far_in_t;

  typedef struct packed {
    logic signed [SUM_NUM_W-1:0] sum_num;
    logic [SUM_DEN_W-1:0]        sum_den;
    logic                        zero_denominator;
  } far_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_GCD_TWO,
    ST_GCD_RUN,
    ST_DIV_NUM,
    ST_DIV_DEN
  } far_state_t;

  typedef enum logic [1:0] {
    MUL_AD,
    MUL_CB,
    MUL_BD,
    MUL_END
  } far_mstep_t;

endpackage

@@ sv/fraction_add_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_add_reduce
// adds two signed fractions and reduces the sum by a binary gcd
// a zero denominator is answered from idle with a flagged result;
// else multiply steps, abs, gcd steps, then numerator and denominator divides
// start is ignored while busy; one transfer at a time uses the shared divider
// sync reset clears the sequencer and done; busy is low after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fraction_add_reduce import far_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  far_in_t  operands,
  output logic     done,
  output far_out_t result
);

  far_state_t state, state_next;
  far_mstep_t mstep;

  far_in_t             item;
  logic signed [PW-1:0] mul_reg;
  logic signed [PW:0]   acc;
  logic [PW-1:0]        x;
  logic [PW-1:0]        y;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        dmag;
  logic                 neg;
  logic [PW-1:0]        qnum;

  logic signed [IN_WIDTH-1:0] mul_op1;
  logic signed [IN_WIDTH-1:0] mul_op2;
  logic                       zero_in;
  logic [PW:0]                diff_xy;
  logic [PW:0]                diff_yx;
  logic [PW:0]                acc_abs;
  logic [PW-1:0]              den_abs;
  logic                       div_start;
  logic [PW-1:0]              div_dividend;
  logic                       div_done;
  logic [PW-1:0]              div_quot;
  logic [EXT_W-1:0]           num_ext;

  far_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (y),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign zero_in = (operands.den_a == '0) || (operands.den_b == '0);
  assign diff_xy = {1'b0, x} - {1'b0, y};
  assign diff_yx = {1'b0, y} - {1'b0, x};
  assign acc_abs = acc[PW] ? -acc : acc;
  assign den_abs = mul_reg[PW-1] ? -mul_reg : mul_reg;
  assign num_ext = neg ? -EXT_W'(qnum) : EXT_W'(qnum);

  always_comb begin
    unique case (mstep)
      MUL_AD:  begin mul_op1 = item.num_a; mul_op2 = item.den_b; end
      MUL_CB:  begin mul_op1 = item.num_b; mul_op2 = item.den_a; end
      default: begin mul_op1 = item.den_a; mul_op2 = item.den_b; end
    endcase
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = mag;
    unique case (state)
      ST_IDLE: begin
        if (start && !zero_in) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mstep == MUL_END) state_next = ST_ABS;
      end
      ST_ABS: state_next = ST_GCD_TWO;
      ST_GCD_TWO: begin
        if (x == '0) begin
          state_next = ST_DIV_NUM;
          div_start  = 1'b1;
        end else if (x[0] || y[0]) begin
          state_next = ST_GCD_RUN;
        end
      end
      ST_GCD_RUN: begin
        if (x == '0) begin
          state_next = ST_DIV_NUM;
          div_start  = 1'b1;
        end
      end
      ST_DIV_NUM: begin
        if (div_done) begin
          state_next   = ST_DIV_DEN;
          div_start    = 1'b1;
          div_dividend = dmag;
        end
      end
      ST_DIV_DEN: begin
        if (div_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            item  <= operands;
            mstep <= MUL_AD;
            if (zero_in) begin
              result <= '{sum_num: '0, sum_den: '0, zero_denominator: 1'b1};
              done   <= 1'b1;
            end
          end
        end
        ST_MUL: begin
          mul_reg <= mul_op1 * mul_op2;
          mstep   <= far_mstep_t'(mstep + 2'd1);
          unique case (mstep)
            MUL_AD:  acc <= '0;
            MUL_CB:  acc <= {mul_reg[PW-1], mul_reg};
            MUL_BD:  acc <= acc + {mul_reg[PW-1], mul_reg};
            default: acc <= acc;
          endcase
        end
        ST_ABS: begin
          x    <= acc_abs[PW-1:0];
          mag  <= acc_abs[PW-1:0];
          y    <= den_abs;
          dmag <= den_abs;
          neg  <= acc[PW] ^ mul_reg[PW-1];
        end
        ST_GCD_TWO: begin
          if (x != '0 && !x[0] && !y[0]) begin
            x    <= x >> 1;
            y    <= y >> 1;
            mag  <= mag >> 1;
            dmag <= dmag >> 1;
          end
        end
        ST_GCD_RUN: begin
          if (x == '0) begin
            x <= x;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (!diff_xy[PW]) begin
            x <= diff_xy[PW:1];
          end else begin
            y <= diff_yx[PW:1];
          end
        end
        ST_DIV_NUM: begin
          if (div_done) qnum <= div_quot;
        end
        ST_DIV_DEN: begin
          if (div_done) begin
            result <= '{sum_num: num_ext[SUM_NUM_W-1:0],
                        sum_den: SUM_DEN_W'(div_quot),
                        zero_denominator: 1'b0};
            done   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ sv/far_div.sv @@
// ----------------------------------------------------------------------------
// far_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module far_div import far_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [PW-1:0] divisor,
  output logic          done,
  output logic [PW-1:0] quotient
);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    rem;
  logic [PW-1:0]    quot;
  logic [PW-1:0]    dvs;
  logic [PW:0]      trial;
  logic [PW:0]      diff;
  logic [PW-1:0]    rem_next;
  logic [PW-1:0]    quot_next;

  always_comb begin
    trial = {rem, quot[PW-1]};
    diff  = trial - {1'b0, dvs};
    if (diff[PW]) begin
      rem_next  = trial[PW-1:0];
      quot_next = {quot[PW-2:0], 1'b0};
    end else begin
      rem_next  = diff[PW-1:0];
      quot_next = {quot[PW-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quot    <= dividend;
        dvs     <= divisor;
      end else if (running) begin
        rem  <= rem_next;
        quot <= quot_next;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(PW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quot;

endmodule

@@ sv/far_chk.sv @@
// ----------------------------------------------------------------------------
// far_chk
// port-level checks on the fraction adder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module far_chk import far_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input far_out_t result
);

  // an accepted transfer either starts work or answers at once
  `ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  // work only ends with a result
  `ASSERT_NXT(a_busy_ends_done, busy, busy || done)
  // a result is never shown while still working
  `ASSERT_IMP(a_done_idle, done, !busy)
  // error results carry zero parts
  `ASSERT_IMP(a_zero_den, done && result.zero_denominator,
              result.sum_num == '0 && result.sum_den == '0)
  // good results have a positive denominator
  `ASSERT_IMP(a_den_nonzero, done && !result.zero_denominator, result.sum_den != '0)

endmodule

bind fraction_add_reduce far_chk u_far_chk (.*);
